// File: rtl/sst_pkg.sv
// shared types, constants and the control program of the state space step block
package sst_pkg;

  localparam int NUM_STATES = 4;
  localparam int MaxStates  = 4;
  localparam int IdxW       = 2;
  localparam int NumW       = IdxW + 1;
  localparam int DataW      = 32;
  localparam int CoefW      = 16;
  localparam int DtW        = 16;
  localparam int RegW       = 64;
  localparam int CfgIdxW    = 3;
  localparam int OpAW       = DataW + 1;
  localparam int OpBW       = CoefW + 1;
  localparam int ProdW      = OpAW + OpBW;
  localparam int AccW       = ProdW + 2;
  localparam int CoefShift  = 12;
  localparam int DtShift    = 17;
  localparam int ProgLen    = 33;
  localparam int PcW        = $clog2(ProgLen);
  localparam logic [PcW-1:0] PcMeas = PcW'(29);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DYN0  = 3'd0,
    CFG_DYN1  = 3'd1,
    CFG_DYN2  = 3'd2,
    CFG_DYN3  = 3'd3,
    CFG_BGAIN = 3'd4,
    CFG_HGAIN = 3'd5,
    CFG_TSTEP = 3'd6
  } cfg_idx_e;

  typedef enum logic {OP_MAC, OP_LOAD} op_e;
  typedef enum logic [1:0] {A_U, A_X, A_DSUM} asel_e;
  typedef enum logic [1:0] {B_IN, B_DYN, B_MEAS, B_DT} bsel_e;
  typedef enum logic [2:0] {
    ACT_NONE, ACT_CLR, ACT_ACC, ACT_DLAST, ACT_UPD, ACT_MLAST
  } act_e;
  typedef enum logic [1:0] {JMP_NEXT, JMP_LOAD, JMP_END} jmp_e;

  typedef struct packed {
    op_e            op;
    asel_e          a_sel;
    bsel_e          b_sel;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    act_e           act;
    jmp_e           jmp;
    logic           wait_out;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    asel_e           a_sel;
    bsel_e           b_sel;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    act_e            act;
    logic            load_en;
  } sst_issue_t;

  typedef struct packed {
    logic [MaxStates-1:0][RegW-1:0] dyn;
    logic [RegW-1:0]                b_gain;
    logic [RegW-1:0]                h_gain;
    logic [DtW-1:0]                 dt;
  } sst_cfg_t;

  typedef struct packed {
    logic                    done;
    logic signed [DataW-1:0] meas;
  } sst_wb_t;

  function automatic ucode_t uw(op_e op, asel_e a, bsel_e b, int row, int col,
                                act_e act, jmp_e jmp, logic wt);
    ucode_t w;
    w.op       = op;
    w.a_sel    = a;
    w.b_sel    = b;
    w.row      = IdxW'(row);
    w.col      = IdxW'(col);
    w.act      = act;
    w.jmp      = jmp;
    w.wait_out = wt;
    w.target   = PcMeas;
    return w;
  endfunction

  // one word per step: load check, four derivative rows, state update, measurement
  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      6'd0:  w = uw(OP_LOAD, A_U, B_IN, 0, 0, ACT_NONE, JMP_LOAD, 1'b0);
      6'd1:  w = uw(OP_MAC, A_U, B_IN, 0, 0, ACT_CLR, JMP_NEXT, 1'b0);
      6'd2:  w = uw(OP_MAC, A_X, B_DYN, 0, 0, ACT_ACC, JMP_NEXT, 1'b0);
      6'd3:  w = uw(OP_MAC, A_X, B_DYN, 0, 1, ACT_ACC, JMP_NEXT, 1'b0);
      6'd4:  w = uw(OP_MAC, A_X, B_DYN, 0, 2, ACT_ACC, JMP_NEXT, 1'b0);
      6'd5:  w = uw(OP_MAC, A_X, B_DYN, 0, 3, ACT_DLAST, JMP_NEXT, 1'b0);
      6'd6:  w = uw(OP_MAC, A_U, B_IN, 1, 0, ACT_CLR, JMP_NEXT, 1'b0);
      6'd7:  w = uw(OP_MAC, A_X, B_DYN, 1, 0, ACT_ACC, JMP_NEXT, 1'b0);
      6'd8:  w = uw(OP_MAC, A_X, B_DYN, 1, 1, ACT_ACC, JMP_NEXT, 1'b0);
      6'd9:  w = uw(OP_MAC, A_X, B_DYN, 1, 2, ACT_ACC, JMP_NEXT, 1'b0);
      6'd10: w = uw(OP_MAC, A_X, B_DYN, 1, 3, ACT_DLAST, JMP_NEXT, 1'b0);
      6'd11: w = uw(OP_MAC, A_U, B_IN, 2, 0, ACT_CLR, JMP_NEXT, 1'b0);
      6'd12: w = uw(OP_MAC, A_X, B_DYN, 2, 0, ACT_ACC, JMP_NEXT, 1'b0);
      6'd13: w = uw(OP_MAC, A_X, B_DYN, 2, 1, ACT_ACC, JMP_NEXT, 1'b0);
      6'd14: w = uw(OP_MAC, A_X, B_DYN, 2, 2, ACT_ACC, JMP_NEXT, 1'b0);
      6'd15: w = uw(OP_MAC, A_X, B_DYN, 2, 3, ACT_DLAST, JMP_NEXT, 1'b0);
      6'd16: w = uw(OP_MAC, A_U, B_IN, 3, 0, ACT_CLR, JMP_NEXT, 1'b0);
      6'd17: w = uw(OP_MAC, A_X, B_DYN, 3, 0, ACT_ACC, JMP_NEXT, 1'b0);
      6'd18: w = uw(OP_MAC, A_X, B_DYN, 3, 1, ACT_ACC, JMP_NEXT, 1'b0);
      6'd19: w = uw(OP_MAC, A_X, B_DYN, 3, 2, ACT_ACC, JMP_NEXT, 1'b0);
      6'd20: w = uw(OP_MAC, A_X, B_DYN, 3, 3, ACT_DLAST, JMP_NEXT, 1'b0);
      6'd21: w = uw(OP_MAC, A_DSUM, B_DT, 0, 0, ACT_UPD, JMP_NEXT, 1'b0);
      6'd22: w = uw(OP_MAC, A_DSUM, B_DT, 1, 0, ACT_UPD, JMP_NEXT, 1'b0);
      6'd23: w = uw(OP_MAC, A_DSUM, B_DT, 2, 0, ACT_UPD, JMP_NEXT, 1'b0);
      6'd24: w = uw(OP_MAC, A_DSUM, B_DT, 3, 0, ACT_UPD, JMP_NEXT, 1'b0);
      6'd25: w = uw(OP_MAC, A_X, B_MEAS, 0, 0, ACT_NONE, JMP_NEXT, 1'b0);
      6'd26: w = uw(OP_MAC, A_X, B_MEAS, 0, 0, ACT_NONE, JMP_NEXT, 1'b0);
      6'd27: w = uw(OP_MAC, A_X, B_MEAS, 0, 0, ACT_NONE, JMP_NEXT, 1'b0);
      6'd28: w = uw(OP_MAC, A_X, B_MEAS, 0, 0, ACT_NONE, JMP_NEXT, 1'b0);
      6'd29: w = uw(OP_MAC, A_X, B_MEAS, 0, 0, ACT_CLR, JMP_NEXT, 1'b0);
      6'd30: w = uw(OP_MAC, A_X, B_MEAS, 0, 1, ACT_ACC, JMP_NEXT, 1'b0);
      6'd31: w = uw(OP_MAC, A_X, B_MEAS, 0, 2, ACT_ACC, JMP_NEXT, 1'b0);
      6'd32: w = uw(OP_MAC, A_X, B_MEAS, 0, 3, ACT_MLAST, JMP_END, 1'b1);
      default: w = uw(OP_MAC, A_X, B_MEAS, 0, 0, ACT_NONE, JMP_END, 1'b0);
    endcase
    return w;
  endfunction

  function automatic logic in_range(logic [IdxW-1:0] idx);
    return {1'b0, idx} < NumW'(NUM_STATES);
  endfunction

  function automatic logic signed [CoefW-1:0] lane(logic [RegW-1:0] r,
                                                   logic [IdxW-1:0] k);
    return r[CoefW*k +: CoefW];
  endfunction

  function automatic logic signed [DataW-1:0] sat32(logic signed [AccW-1:0] v);
    logic [AccW-DataW:0] top;
    top = v[AccW-1:DataW-1];
    if ((&top) || !(|top)) begin
      return v[DataW-1:0];
    end
    return v[AccW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
  endfunction

endpackage

// File: rtl/sst_if.sv
// request and response channel interfaces of the state space step block
interface sst_req_if import sst_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [DataW-1:0] control_in;
  logic [IdxW-1:0]         load_index;
  logic signed [DataW-1:0] load_value;

  modport source (output valid, req_type, control_in, load_index, load_value,
                  input ready);
  modport sink (input valid, req_type, control_in, load_index, load_value,
                output ready);
endinterface

interface sst_rsp_if import sst_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] state_0;
  logic signed [DataW-1:0] state_1;
  logic signed [DataW-1:0] state_2;
  logic signed [DataW-1:0] state_3;
  logic signed [DataW-1:0] measurement;

  modport source (output valid, state_0, state_1, state_2, state_3, measurement,
                  input ready);
  modport sink (input valid, state_0, state_1, state_2, state_3, measurement,
                output ready);
endinterface

// File: rtl/sst_datapath.sv
// shared multiply-accumulate datapath with state and derivative registers
module sst_datapath import sst_pkg::*; (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sst_issue_t                            issue_i,
  input  sst_cfg_t                              cfg_i,
  input  logic signed [DataW-1:0]               ctrl_i,
  input  logic [IdxW-1:0]                       load_idx_i,
  input  logic signed [DataW-1:0]               load_val_i,
  output sst_wb_t                               wb_o,
  output logic [MaxStates-1:0][DataW-1:0]       state_o
);

  logic signed [DataW-1:0] x_q     [MaxStates];
  logic signed [DataW-1:0] dprev_q [MaxStates];
  logic signed [DataW-1:0] dnew_q  [MaxStates];
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  act_e                    act_q;
  logic [IdxW-1:0]         row_q;

  logic signed [OpAW-1:0]  op_a;
  logic signed [OpBW-1:0]  op_b;
  logic signed [CoefW-1:0] coef;
  logic                    row_ok, col_ok;
  logic signed [AccW-1:0]  acc_base, prod_ext, sum, sum_sh;
  logic signed [DataW-1:0] sum_sat;
  logic signed [OpAW:0]    upd_sum;
  logic signed [DataW-1:0] upd_sat;
  logic signed [ProdW-DtShift-1:0] inc;

  // operand select for the issuing control word
  always_comb begin
    row_ok = in_range(issue_i.row);
    col_ok = in_range(issue_i.col);
    coef   = '0;
    op_a   = '0;
    op_b   = '0;
    unique case (issue_i.a_sel)
      A_U:     op_a = {ctrl_i[DataW-1], ctrl_i};
      A_X:     op_a = col_ok ? {x_q[issue_i.col][DataW-1], x_q[issue_i.col]} : '0;
      A_DSUM:  op_a = {dprev_q[issue_i.row][DataW-1], dprev_q[issue_i.row]}
                    + {dnew_q[issue_i.row][DataW-1], dnew_q[issue_i.row]};
      default: op_a = '0;
    endcase
    unique case (issue_i.b_sel)
      B_IN:    coef = row_ok ? lane(cfg_i.b_gain, issue_i.row) : '0;
      B_DYN:   coef = (row_ok && col_ok) ? lane(cfg_i.dyn[issue_i.row], issue_i.col) : '0;
      B_MEAS:  coef = col_ok ? lane(cfg_i.h_gain, issue_i.col) : '0;
      default: coef = '0;
    endcase
    op_b = (issue_i.b_sel == B_DT) ? {1'b0, cfg_i.dt} : {coef[CoefW-1], coef};
  end

  // accumulate stage
  always_comb begin
    prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    acc_base = (act_q == ACT_CLR) ? '0 : acc_q;
    sum      = acc_base + prod_ext;
    sum_sh   = sum >>> CoefShift;
    sum_sat  = sat32(sum_sh);
    inc      = prod_q[ProdW-1:DtShift];
    upd_sum  = {{2{x_q[row_q][DataW-1]}}, x_q[row_q]} + {inc[OpAW-1], inc};
    upd_sat  = sat32({{(AccW-OpAW-1){upd_sum[OpAW]}}, upd_sum});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACT_NONE;
    end else begin
      act_q <= issue_i.act;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    row_q  <= issue_i.row;
    if (act_q == ACT_CLR || act_q == ACT_ACC) begin
      acc_q <= sum;
    end
    if (act_q == ACT_DLAST && in_range(row_q)) begin
      dnew_q[row_q] <= sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxStates; i++) begin
        x_q[i]     <= '0;
        dprev_q[i] <= '0;
      end
    end else if (issue_i.load_en && in_range(load_idx_i)) begin
      x_q[load_idx_i] <= load_val_i;
    end else if (act_q == ACT_UPD && in_range(row_q)) begin
      x_q[row_q]     <= upd_sat;
      dprev_q[row_q] <= dnew_q[row_q];
    end
  end

  assign wb_o.done = (act_q == ACT_MLAST);
  assign wb_o.meas = sum_sat;

  always_comb begin
    for (int k = 0; k < MaxStates; k++) begin
      state_o[k] = x_q[k];
    end
  end

endmodule

// File: rtl/state_space_trapezoid_step.sv
// top level: linear plant step simulator with a microcoded multiply-accumulate sequencer
// Usage:
//   req_ch takes one transaction per item: req_type 0 advances the plant one
//   time step with control input control_in, req_type 1 writes load_value into
//   state element load_index. rsp_ch returns one transaction per item with the
//   four state elements and the measurement H x after the item. Configuration
//   is a write-only register port (cfg_we_i, cfg_index_i, cfg_data_i); the user
//   must write it only while no item is in flight; the block does not enforce it.
// Timing:
//   Items are worked one at a time by a 33-word control program driving a
//   single 33x17 multiplier followed by an accumulate stage. A step item runs
//   the whole program; a load item runs the load word, then the four
//   measurement words, then the accumulate stage. The next item is accepted
//   in the cycle after the final program word issues. The program issues one
//   multiply per cycle, except while the final word stalls.
// Reset and stalls:
//   Reset clears state and kept derivative and sets the configuration
//   registers to their reset values (time_step to 655). The result sits in
//   an output register; if it is still not taken when the next result is
//   due, the final program word holds until the output register frees up.
module state_space_trapezoid_step import sst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  sst_req_if.sink            req_ch,
  sst_rsp_if.source          rsp_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [RegW-1:0]    cfg_data_i
);

  sst_cfg_t cfg_q;

  logic                    busy_q;
  logic [PcW-1:0]          pc_q;
  logic                    req_load_q;
  logic signed [DataW-1:0] ctrl_q;
  logic [IdxW-1:0]         load_idx_q;
  logic signed [DataW-1:0] load_val_q;

  logic                                rsp_valid_q;
  logic [MaxStates-1:0][DataW-1:0]     rsp_state_q;
  logic signed [DataW-1:0]             rsp_meas_q;

  ucode_t                          uword;
  sst_issue_t                      issue;
  sst_wb_t                         wb;
  logic [MaxStates-1:0][DataW-1:0] dp_state;
  logic                            out_free, stall, fire, accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dyn    <= '0;
      cfg_q.b_gain <= '0;
      cfg_q.h_gain <= '0;
      cfg_q.dt     <= DtW'(655);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DYN0:  cfg_q.dyn[0]  <= cfg_data_i;
        CFG_DYN1:  cfg_q.dyn[1]  <= cfg_data_i;
        CFG_DYN2:  cfg_q.dyn[2]  <= cfg_data_i;
        CFG_DYN3:  cfg_q.dyn[3]  <= cfg_data_i;
        CFG_BGAIN: cfg_q.b_gain  <= cfg_data_i;
        CFG_HGAIN: cfg_q.h_gain  <= cfg_data_i;
        CFG_TSTEP: cfg_q.dt      <= cfg_data_i[DtW-1:0];
        default:   ;
      endcase
    end
  end

  assign req_ch.ready = !busy_q;
  assign accept       = req_ch.valid && !busy_q;

  // the final word may only issue if the output register is free in the next cycle
  assign uword    = ucode_rom(pc_q);
  assign out_free = !rsp_valid_q || rsp_ch.ready;
  assign stall    = uword.wait_out && !out_free;
  assign fire     = busy_q && !stall;

  always_comb begin
    issue.a_sel   = uword.a_sel;
    issue.b_sel   = uword.b_sel;
    issue.row     = uword.row;
    issue.col     = uword.col;
    issue.act     = fire ? uword.act : ACT_NONE;
    issue.load_en = fire && (uword.op == OP_LOAD) && req_load_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      pc_q   <= '0;
    end else if (fire) begin
      unique case (uword.jmp)
        JMP_NEXT: pc_q <= pc_q + 1'b1;
        JMP_LOAD: pc_q <= req_load_q ? uword.target : pc_q + 1'b1;
        JMP_END:  busy_q <= 1'b0;
        default:  busy_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_load_q <= req_ch.req_type;
      ctrl_q     <= req_ch.control_in;
      load_idx_q <= req_ch.load_index;
      load_val_q <= req_ch.load_value;
    end
  end

  sst_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .cfg_i      (cfg_q),
    .ctrl_i     (ctrl_q),
    .load_idx_i (load_idx_q),
    .load_val_i (load_val_q),
    .wb_o       (wb),
    .state_o    (dp_state)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (wb.done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ch.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb.done) begin
      rsp_state_q <= dp_state;
      rsp_meas_q  <= wb.meas;
    end
  end

  assign rsp_ch.valid       = rsp_valid_q;
  assign rsp_ch.state_0     = rsp_state_q[0];
  assign rsp_ch.state_1     = rsp_state_q[1];
  assign rsp_ch.state_2     = rsp_state_q[2];
  assign rsp_ch.state_3     = rsp_state_q[3];
  assign rsp_ch.measurement = rsp_meas_q;

endmodule

// File: dv/testbench.sv
// testbench of the state space trapezoid step block: directed table, random phases, predictor
`timescale 1ns / 100ps

module testbench import sst_pkg::*;;

  localparam logic ReqStep = 1'b0;
  localparam logic ReqLoad = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  localparam logic [DtW-1:0] DtReset = 16'd655;
  localparam longint SatHi = 2147483647;
  localparam longint SatLo = -SatHi - 1;
  localparam int SettleCycles = 40;
  localparam int NumPhases = 5;
  localparam int ItemsPerPhase = 100;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 400000;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {MIX_GENTLE, MIX_FULL, MIX_EXTREME} lane_mix_e;

  typedef struct packed {
    logic [DataW-1:0] st0;
    logic [DataW-1:0] st1;
    logic [DataW-1:0] st2;
    logic [DataW-1:0] st3;
    logic [DataW-1:0] meas;
  } plant_report_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [RegW-1:0]    reg_val;
    logic               req_type;
    logic [DataW-1:0]   ctl;
    logic [IdxW-1:0]    idx;
    logic [DataW-1:0]   val;
    logic               typed;
    plant_report_t      rpt;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [RegW-1:0]    cfg_data_i;

  sst_req_if req_ch ();
  sst_rsp_if rsp_ch ();

  state_space_trapezoid_step i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_ch     (req_ch),
    .rsp_ch     (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // plant model: registers and state as the block should hold them
  logic [RegW-1:0]         dyn_coef [MaxStates];
  logic [RegW-1:0]         u_gain;
  logic [RegW-1:0]         z_gain;
  logic [DtW-1:0]          step_len;
  logic signed [DataW-1:0] plant_x [MaxStates];
  logic signed [DataW-1:0] plant_dprev [MaxStates];

  plant_report_t report_q [$];
  plant_report_t seen_rpt;
  plant_report_t want_rpt;
  int  mismatch_count;
  int  rsp_count;
  int  cycle_count;
  int  hold_len;
  bit  calm;
  bit  reg_port_open;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint coef_of(logic [RegW-1:0] r, int k);
    logic signed [CoefW-1:0] c16;
    c16 = r[CoefW*k +: CoefW];
    return longint'(c16);
  endfunction

  function automatic logic signed [DataW-1:0] clamp32(longint v);
    if (v > SatHi) begin
      return DataW'(SatHi);
    end
    if (v < SatLo) begin
      return DataW'(SatLo);
    end
    return DataW'(v);
  endfunction

  // applies one transaction to the plant model and returns the report it yields
  function automatic plant_report_t advance_plant(logic rt, logic signed [DataW-1:0] u,
                                                  logic [IdxW-1:0] li,
                                                  logic signed [DataW-1:0] lv);
    longint acc;
    longint dsum;
    longint inc;
    logic signed [DataW-1:0] dnew [MaxStates];
    logic signed [DataW-1:0] shown [MaxStates];
    plant_report_t rpt;
    for (int r = 0; r < MaxStates; r++) begin
      dnew[r] = '0;
    end
    if (rt == ReqStep) begin
      for (int r = 0; r < NUM_STATES; r++) begin
        acc = longint'(u) * coef_of(u_gain, r);
        for (int c = 0; c < NUM_STATES; c++) begin
          acc += longint'(plant_x[c]) * coef_of(dyn_coef[r], c);
        end
        dnew[r] = clamp32(acc >>> CoefShift);
      end
      for (int r = 0; r < NUM_STATES; r++) begin
        dsum = longint'(plant_dprev[r]) + longint'(dnew[r]);
        inc = (dsum * longint'(step_len)) >>> DtShift;
        plant_x[r] = clamp32(longint'(plant_x[r]) + inc);
        plant_dprev[r] = dnew[r];
      end
    end else if (int'(li) < NUM_STATES) begin
      plant_x[li] = lv;
    end
    acc = 0;
    for (int c = 0; c < NUM_STATES; c++) begin
      acc += longint'(plant_x[c]) * coef_of(z_gain, c);
    end
    for (int k = 0; k < MaxStates; k++) begin
      shown[k] = (k < NUM_STATES) ? plant_x[k] : '0;
    end
    rpt.st0 = shown[0];
    rpt.st1 = shown[1];
    rpt.st2 = shown[2];
    rpt.st3 = shown[3];
    rpt.meas = clamp32(acc >>> CoefShift);
    return rpt;
  endfunction

  function automatic logic [RegW-1:0] make_coefs(lane_mix_e mix);
    logic [RegW-1:0] w;
    int g;
    for (int k = 0; k < MaxStates; k++) begin
      case (mix)
        MIX_FULL: begin
          w[CoefW*k +: CoefW] = CoefW'($urandom);
        end
        MIX_EXTREME: begin
          case ($urandom_range(3))
            0: w[CoefW*k +: CoefW] = 16'h7FFF;
            1: w[CoefW*k +: CoefW] = 16'h8000;
            2: w[CoefW*k +: CoefW] = 16'h0000;
            default: w[CoefW*k +: CoefW] = 16'hFFFF;
          endcase
        end
        default: begin
          // within a quarter either way keeps most states off the rails
          g = int'($urandom_range(2048)) - 1024;
          w[CoefW*k +: CoefW] = CoefW'(g);
        end
      endcase
    end
    return w;
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    int s;
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: begin
        s = int'($urandom_range(1 << 20)) - (1 << 19);
        return DataW'(s);
      end
    endcase
  endfunction

  function automatic dir_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic dir_row_t item_row(logic rt, logic [DataW-1:0] ctl, logic [IdxW-1:0] li,
                                        logic [DataW-1:0] lv);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.req_type = rt;
    row.ctl = ctl;
    row.idx = li;
    row.val = lv;
    return row;
  endfunction

  function automatic dir_row_t typed_row(logic rt, logic [DataW-1:0] ctl, logic [IdxW-1:0] li,
                                         logic [DataW-1:0] lv, logic [DataW-1:0] x0,
                                         logic [DataW-1:0] x1, logic [DataW-1:0] x2,
                                         logic [DataW-1:0] x3, logic [DataW-1:0] z);
    dir_row_t row;
    row = item_row(rt, ctl, li, lv);
    row.typed = 1'b1;
    row.rpt = '{st0: x0, st1: x1, st2: x2, st3: x3, meas: z};
    return row;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] data);
    if (!reg_port_open) begin
      req_ch.valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
    end
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_DYN0, CFG_DYN1, CFG_DYN2, CFG_DYN3: dyn_coef[idx[IdxW-1:0]] = data;
      CFG_BGAIN: u_gain = data;
      CFG_HGAIN: z_gain = data;
      CFG_TSTEP: step_len = data[DtW-1:0];
      default: ;
    endcase
    reg_port_open = 1'b1;
  endtask

  task automatic offer_item(input logic rt, input logic [DataW-1:0] ctl,
                            input logic [IdxW-1:0] li, input logic [DataW-1:0] lv,
                            input bit typed, input plant_report_t typed_rpt);
    int gap;
    plant_report_t rpt;
    if (reg_port_open) begin
      cfg_we_i <= 1'b0;
      reg_port_open = 1'b0;
    end
    gap = (!calm && $urandom_range(99) < 15) ? int'($urandom_range(40, 1)) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rt;
    req_ch.control_in <= ctl;
    req_ch.load_index <= li;
    req_ch.load_value <= lv;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    rpt = advance_plant(rt, ctl, li, lv);
    report_q.push_back(typed ? typed_rpt : rpt);
  endtask

  task automatic check_field(input string fld, input logic [DataW-1:0] want,
                             input logic [DataW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result %0d %s: expected %h got %h", rsp_count, fld, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      seen_rpt = '{st0: rsp_ch.state_0, st1: rsp_ch.state_1, st2: rsp_ch.state_2,
                   st3: rsp_ch.state_3, meas: rsp_ch.measurement};
      if (report_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result %0d arrived with nothing pending: %h", rsp_count, seen_rpt);
        end
      end else begin
        want_rpt = report_q.pop_front();
        check_field("state_0", want_rpt.st0, seen_rpt.st0);
        check_field("state_1", want_rpt.st1, seen_rpt.st1);
        check_field("state_2", want_rpt.st2, seen_rpt.st2);
        check_field("state_3", want_rpt.st3, seen_rpt.st3);
        check_field("measurement", want_rpt.meas, seen_rpt.meas);
      end
      rsp_count++;
    end
  end

  // receiver: random stalls, a calm stretch, and one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    logic rt;
    logic [DataW-1:0] ctl;
    logic [DataW-1:0] lv;
    logic [IdxW-1:0] li;
    logic [RegW-1:0] dt_word;
    lane_mix_e mix;

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= '0;
    cfg_data_i        <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= ReqStep;
    req_ch.control_in <= '0;
    req_ch.load_index <= '0;
    req_ch.load_value <= '0;
    mismatch_count = 0;
    rsp_count = 0;
    cycle_count = 0;
    hold_len = 0;
    calm = 1'b0;
    reg_port_open = 1'b0;
    for (int k = 0; k < MaxStates; k++) begin
      dyn_coef[k] = '0;
      plant_x[k] = '0;
      plant_dprev[k] = '0;
    end
    u_gain = '0;
    z_gain = '0;
    step_len = DtReset;

    // with all gains zero nothing moves but loads; the weights then saturate the measurement
    dir_tab.push_back(typed_row(ReqStep, 32'h7FFF_FFFF, 2'd3, 32'hFFFF_FFFF,
                                32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    dir_tab.push_back(reg_row(CfgUnused, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_tab.push_back(typed_row(ReqLoad, 32'h0, 2'd0, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0));
    dir_tab.push_back(typed_row(ReqLoad, 32'h0, 2'd1, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0));
    dir_tab.push_back(typed_row(ReqLoad, 32'h0, 2'd2, 32'hFFFF_FFFF,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0));
    dir_tab.push_back(typed_row(ReqLoad, 32'h0, 2'd3, 32'h0000_0001,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h0));
    dir_tab.push_back(typed_row(ReqStep, 32'h8000_0000, 2'd0, 32'h0,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h0));
    dir_tab.push_back(reg_row(CFG_HGAIN, 64'h7FFF_7FFF_7FFF_7FFF));
    dir_tab.push_back(typed_row(ReqLoad, 32'h0, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF));
    dir_tab.push_back(reg_row(CFG_HGAIN, 64'h8000_8000_8000_8000));
    dir_tab.push_back(typed_row(ReqLoad, 32'h0, 2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000));
    // upper bits of the time step word are dropped
    dir_tab.push_back(reg_row(CFG_TSTEP, 64'hABCD_0000_0000_FFFF));
    dir_tab.push_back(reg_row(CFG_DYN0, 64'h7FFF_8000_7FFF_8000));
    dir_tab.push_back(reg_row(CFG_DYN1, 64'h8000_7FFF_8000_7FFF));
    dir_tab.push_back(reg_row(CFG_DYN2, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_tab.push_back(reg_row(CFG_DYN3, 64'h0001_0000_1000_F000));
    dir_tab.push_back(reg_row(CFG_BGAIN, 64'h7FFF_8000_0001_FFFF));
    dir_tab.push_back(item_row(ReqStep, 32'h7FFF_FFFF, 2'd0, 32'h0));
    dir_tab.push_back(item_row(ReqStep, 32'h8000_0000, 2'd0, 32'h0));
    dir_tab.push_back(item_row(ReqLoad, 32'h0, 2'd3, 32'h8000_0000));
    dir_tab.push_back(item_row(ReqStep, 32'h0, 2'd0, 32'h0));
    dir_tab.push_back(item_row(ReqStep, 32'h0001_0000, 2'd0, 32'h0));
    // zero step length: state holds while the kept derivative still moves
    dir_tab.push_back(reg_row(CFG_TSTEP, 64'h0));
    dir_tab.push_back(item_row(ReqStep, 32'h7FFF_FFFF, 2'd0, 32'h0));
    dir_tab.push_back(reg_row(CFG_HGAIN, 64'h0001_FFFF_1000_F000));
    dir_tab.push_back(item_row(ReqStep, 32'h5555_5555, 2'd1, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row(ReqLoad, 32'h0, 2'd0, 32'hAAAA_AAAA));
    dir_tab.push_back(item_row(ReqLoad, 32'h0, 2'd2, 32'h0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        offer_item(dir_tab[i].req_type, dir_tab[i].ctl, dir_tab[i].idx, dir_tab[i].val,
                   dir_tab[i].typed, dir_tab[i].rpt);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      mix = (p == 1) ? MIX_FULL : (p == 2) ? MIX_EXTREME : MIX_GENTLE;
      for (int r = CFG_DYN0; r <= CFG_HGAIN; r++) begin
        write_reg(CfgIdxW'(r), make_coefs(mix));
      end
      dt_word = {$urandom, $urandom};
      if (p == 2) begin
        dt_word[DtW-1:0] = 16'hFFFF;
      end else if (p == 4) begin
        dt_word[DtW-1:0] = 16'h0000;
      end
      write_reg(CFG_TSTEP, dt_word);
      write_reg(CfgUnused, {$urandom, $urandom});
      calm = (p == 2);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // receiver backs off for a long while so the block fills and stalls its input
        if (p == 3 && n == 10) begin
          hold_len = HoldCycles;
        end
        rt = ($urandom_range(99) < 70) ? ReqStep : ReqLoad;
        ctl = pick_word();
        li = IdxW'($urandom_range(3));
        lv = pick_word();
        offer_item(rt, ctl, li, lv, 1'b0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    if (reg_port_open) begin
      cfg_we_i <= 1'b0;
    end
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && report_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
